/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL modules of the cellular automaton block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/tca_pkg.sv */
// Package with types, constants and helper functions of the cellular automaton block.
package tca_pkg;

  localparam int unsigned ROW_W      = 64;
  localparam int unsigned WIDTH_W    = $clog2(ROW_W + 1);
  localparam int unsigned ROW_IDX_W  = $clog2(ROW_W);
  localparam int unsigned RULE_W     = 6;
  localparam int unsigned GEN_W      = 16;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned MIN_CELLS  = 5;
  localparam int unsigned MAX_CELLS_DEF = 64;

  typedef enum logic [0:0] {
    CFG_RULE_CODE = 1'b0,
    CFG_ROW_WIDTH = 1'b1
  } cfg_reg_t;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  typedef struct packed {
    logic               load;
    logic               step;
    logic [RULE_W-1:0]  rule;
    logic [WIDTH_W-1:0] width;
  } tca_ctrl_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [GEN_W-1:0] gen;
  } tca_result_t;

  function automatic logic rule_bit(input logic [RULE_W-1:0] rule,
                                    input logic [CNT_W-1:0] count);
    logic res;
    case (count)
      3'd0: res = rule[0];
      3'd1: res = rule[1];
      3'd2: res = rule[2];
      3'd3: res = rule[3];
      3'd4: res = rule[4];
      3'd5: res = rule[5];
      default: res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

/* hw/rtl/tca_cell.sv */
// One cell of the ring: holds a single cell state and applies the totalistic rule.
module tca_cell
  import tca_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  tca_ctrl_t ctrl,
  input  logic      seed_bit,
  input  logic      left2,
  input  logic      left1,
  input  logic      right1,
  input  logic      right2,
  input  logic      head0,
  input  logic      head1,
  output logic      cell_nxt,
  output logic      cell_q
);

  localparam logic [WIDTH_W-1:0] POS  = WIDTH_W'(IDX);
  localparam logic [WIDTH_W-1:0] POS1 = WIDTH_W'(IDX + 1);
  localparam logic [WIDTH_W-1:0] POS2 = WIDTH_W'(IDX + 2);

  logic             cell_r;
  logic             active;
  logic             r1_sel;
  logic             r2_sel;
  logic [CNT_W-1:0] count;
  logic             rule_out;

  always_comb begin
    active = (POS < ctrl.width);
    r1_sel = (ctrl.width == POS1) ? head0 : right1;
    if (ctrl.width == POS2) begin
      r2_sel = head0;
    end else if (ctrl.width == POS1) begin
      r2_sel = head1;
    end else begin
      r2_sel = right2;
    end
    count = CNT_W'(left2) + CNT_W'(left1) + CNT_W'(cell_r) + CNT_W'(r1_sel)
          + CNT_W'(r2_sel);
    rule_out = rule_bit(ctrl.rule, count);
    if (ctrl.load) begin
      cell_nxt = seed_bit & active;
    end else if (ctrl.step) begin
      cell_nxt = rule_out & active;
    end else begin
      cell_nxt = cell_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r <= 1'b0;
    end else begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_q = cell_r;

endmodule

/* hw/rtl/tca_out_buf.sv */
// Two-word output buffer with a skid stage between the cell row and the result channel.
module tca_out_buf
  import tca_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  tca_result_t res_in,
  input  logic        out_stall,
  output logic        full,
  output logic        out_valid,
  output tca_result_t res_out
);

  `include "assert_macros.svh"

  logic        main_valid_r;
  logic        main_valid_nxt;
  tca_result_t main_r;
  tca_result_t main_nxt;
  logic        skid_valid_r;
  logic        skid_valid_nxt;
  tca_result_t skid_r;
  tca_result_t skid_nxt;
  logic        pop;

  always_comb begin
    pop            = main_valid_r & ~out_stall;
    main_valid_nxt = main_valid_r;
    main_nxt       = main_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_nxt       = res_in;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res_in;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign res_out   = main_r;

  `ASSERT_IMPL(a_skid_behind_main, skid_valid_r, main_valid_r, "skid word without main word")
  `ASSERT_NEXT(a_skid_drains, skid_valid_r && !out_stall, main_r == $past(skid_r) && !skid_valid_r, "skid word not moved to main")

endmodule

/* hw/rtl/totalistic_ca_row_step.sv */
// Radius-2 totalistic cellular automaton on a ring of configurable width. The block
// takes one word per clock cycle: a load word replaces the row, a step word advances
// every cell by one generation, since each cell of the row updates in parallel from
// its registered neighbors. Each word yields one result word through a two-word
// output buffer; the input stalls only while both buffer words are occupied.
// Configuration is taken without stall (cfg_ready is tied high) and is meant to be
// written while no word is in flight.
module totalistic_ca_row_step
  import tca_pkg::*;
#(
  parameter int unsigned MAX_CELLS = MAX_CELLS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_op,
  input  logic [ROW_W-1:0]      in_seed_row,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ROW_W-1:0]      out_row_out,
  output logic [GEN_W-1:0]      out_generation,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  `include "assert_macros.svh"

  localparam logic [WIDTH_W-1:0] MAX_W = WIDTH_W'(MAX_CELLS);
  localparam logic [WIDTH_W-1:0] MIN_W = WIDTH_W'(MIN_CELLS);

  logic [RULE_W-1:0]  rule_r;
  logic [WIDTH_W-1:0] width_r;
  logic [WIDTH_W-1:0] width_cfg;
  logic [GEN_W-1:0]   gen_r;
  logic [GEN_W-1:0]   gen_nxt;
  logic               accept;
  logic               buf_full;
  tca_ctrl_t          ctrl;
  tca_result_t        res_in;
  tca_result_t        res_out;
  logic [ROW_W-1:0]   row_q;
  logic [ROW_W-1:0]   row_nxt;
  logic [ROW_W+1:0]   row_ext;
  logic               tail1;
  logic               tail2;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid & ~in_stall;
  assign in_stall  = buf_full;

  always_comb begin
    if (cfg_data < MIN_W) begin
      width_cfg = MIN_W;
    end else if (cfg_data > MAX_W) begin
      width_cfg = MAX_W;
    end else begin
      width_cfg = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_r  <= '0;
      width_r <= MAX_W;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_RULE_CODE: rule_r  <= cfg_data[RULE_W-1:0];
        CFG_ROW_WIDTH: width_r <= width_cfg;
        default: ;
      endcase
    end
  end

  always_comb begin
    ctrl.load  = accept & (op_t'(in_op) == OP_LOAD);
    ctrl.step  = accept & (op_t'(in_op) == OP_STEP);
    ctrl.rule  = rule_r;
    ctrl.width = width_r;
    if (ctrl.load) begin
      gen_nxt = '0;
    end else if (ctrl.step) begin
      gen_nxt = gen_r + GEN_W'(1);
    end else begin
      gen_nxt = gen_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r <= '0;
    end else begin
      gen_r <= gen_nxt;
    end
  end

  assign row_ext = {2'b00, row_q};
  assign tail1   = row_q[ROW_IDX_W'(width_r - WIDTH_W'(1))];
  assign tail2   = row_q[ROW_IDX_W'(width_r - WIDTH_W'(2))];

  for (genvar x = 0; x < ROW_W; x++) begin : g_cells
    if (x < MAX_CELLS) begin : g_live
      logic l1;
      logic l2;
      if (x >= 2) begin : g_l_in
        assign l1 = row_q[x-1];
        assign l2 = row_q[x-2];
      end else if (x == 1) begin : g_l_one
        assign l1 = row_q[0];
        assign l2 = tail1;
      end else begin : g_l_zero
        assign l1 = tail1;
        assign l2 = tail2;
      end
      tca_cell #(
        .IDX(x)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .seed_bit (in_seed_row[x]),
        .left2    (l2),
        .left1    (l1),
        .right1   (row_ext[x+1]),
        .right2   (row_ext[x+2]),
        .head0    (row_q[0]),
        .head1    (row_q[1]),
        .cell_nxt (row_nxt[x]),
        .cell_q   (row_q[x])
      );
    end else begin : g_absent
      assign row_nxt[x] = 1'b0;
      assign row_q[x]   = 1'b0;
    end
  end

  assign res_in.row = row_nxt;
  assign res_in.gen = gen_nxt;

  tca_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .res_in    (res_in),
    .out_stall (out_stall),
    .full      (buf_full),
    .out_valid (out_valid),
    .res_out   (res_out)
  );

  assign out_row_out    = res_out.row;
  assign out_generation = res_out.gen;

  `ASSERT_ALWAYS(a_width_range, width_r >= MIN_W && width_r <= MAX_W, "width out of range")
  `ASSERT_NEXT(a_load_clears_gen, ctrl.load, gen_r == '0, "generation not cleared by load")
  `ASSERT_NEXT(a_step_counts, ctrl.step, gen_r == GEN_W'($past(gen_r) + GEN_W'(1)), "generation not advanced by step")
  `ASSERT_NEXT(a_idle_holds_row, !accept, row_q == $past(row_q) && gen_r == $past(gen_r), "state changed without a word")

endmodule

/* verif/tb_totalistic_ca_row_step.sv */
// Testbench for the radius-2 totalistic cellular automaton row stepper.
module tb_totalistic_ca_row_step;
  import tca_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned RANDOM_WORDS = 440;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned LONG_RUN_STEPS = 48;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_op;
  logic [ROW_W-1:0]      in_seed_row;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [ROW_W-1:0]      out_row_out;
  logic [GEN_W-1:0]      out_generation;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [0:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic [ROW_W-1:0]      ca_row = '0;
  logic [GEN_W-1:0]      gen_count = '0;
  logic [RULE_W-1:0]     rule_reg = '0;
  logic [CFG_DATA_W-1:0] width_reg = 7'd64;

  tca_result_t pending_rows[$];

  bit          quiet = 1'b0;
  int unsigned hold_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned err_count = 0;
  int unsigned n_results = 0;
  int unsigned n_loads = 0;
  int unsigned n_steps = 0;
  int unsigned n_cfg = 0;

  totalistic_ca_row_step uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_op(in_op),
    .in_seed_row(in_seed_row),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_row_out(out_row_out),
    .out_generation(out_generation),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned clamp_width(input logic [CFG_DATA_W-1:0] w);
    if (w < MIN_CELLS) return MIN_CELLS;
    if (w > ROW_W) return ROW_W;
    return w;
  endfunction

  function automatic logic [ROW_W-1:0] live_mask(input int unsigned w);
    if (w >= ROW_W) return '1;
    return (64'd1 << w) - 64'd1;
  endfunction

  function automatic logic [ROW_W-1:0] next_generation(input logic [ROW_W-1:0] row,
                                                       input int unsigned w,
                                                       input logic [RULE_W-1:0] rule);
    logic [ROW_W-1:0] nxt;
    int unsigned      live;
    int unsigned      pos;
    nxt = '0;
    for (int unsigned x = 0; x < w; x++) begin
      live = 0;
      for (int unsigned d = 0; d < 5; d++) begin
        pos = (x + w + d - 2) % w;
        live += row[pos];
      end
      if (rule[live]) nxt[x] = 1'b1;
    end
    return nxt;
  endfunction

  function automatic void predict_result(input op_t op, input logic [ROW_W-1:0] seed);
    tca_result_t r;
    int unsigned w;
    w = clamp_width(width_reg);
    if (op == OP_LOAD) begin
      ca_row = seed & live_mask(w);
      gen_count = '0;
      n_loads++;
    end else begin
      ca_row = next_generation(ca_row & live_mask(w), w, rule_reg);
      gen_count = gen_count + 1'b1;
      n_steps++;
    end
    r.row = ca_row & live_mask(w);
    r.gen = gen_count;
    pending_rows.push_back(r);
  endfunction

  function automatic logic [ROW_W-1:0] random_row();
    logic [ROW_W-1:0] a;
    logic [ROW_W-1:0] b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: return a & b;
      1: return a | b;
      2: return a & b & {$urandom, $urandom};
      default: return a;
    endcase
  endfunction

  function automatic void report_failure(input string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR: %s", msg);
  endfunction

  task automatic send_word(input op_t op, input logic [ROW_W-1:0] seed);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_seed_row <= seed;
    do @(posedge clk); while (in_stall);
    predict_result(op, seed);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_RULE_CODE) rule_reg = data[RULE_W-1:0];
    else width_reg = data;
    n_cfg++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    tca_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pending_rows.size() == 0) begin
        report_failure($sformatf("unexpected result word row %h generation %0d",
                                 out_row_out, out_generation));
      end else begin
        want = pending_rows.pop_front();
        if (out_row_out !== want.row || out_generation !== want.gen) begin
          report_failure($sformatf("row expected %h got %h, generation expected %0d got %0d",
                                   want.row, out_row_out, want.gen, out_generation));
        end
      end
      hold_left = quiet ? 0 : $urandom_range(0, 3);
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic test_reset_defaults();
    send_word(OP_STEP, '1);
    send_word(OP_LOAD, '1);
    send_word(OP_STEP, '0);
    drain();
  endtask

  task automatic test_rule_bits();
    for (int k = 0; k < RULE_W; k++) begin
      write_reg(CFG_RULE_CODE, 7'd1 << k);
      send_word(OP_LOAD, 64'hF0E1_D2C3_B4A5_9687);
      send_word(OP_STEP, {$urandom, $urandom});
      drain();
    end
  endtask

  task automatic test_width_limits();
    write_reg(CFG_ROW_WIDTH, 7'd0);
    write_reg(CFG_RULE_CODE, 7'h7F);
    send_word(OP_LOAD, '1);
    send_word(OP_STEP, '0);
    drain();
    write_reg(CFG_ROW_WIDTH, 7'd127);
    send_word(OP_LOAD, '1);
    send_word(OP_STEP, '0);
    drain();
    write_reg(CFG_ROW_WIDTH, 7'd5);
    write_reg(CFG_RULE_CODE, 7'b0000110);
    send_word(OP_LOAD, 64'h1);
    send_word(OP_STEP, '1);
    drain();
  endtask

  task automatic test_width_change();
    write_reg(CFG_ROW_WIDTH, 7'd64);
    write_reg(CFG_RULE_CODE, 7'b0101010);
    send_word(OP_LOAD, 64'hFFFF_0000_FFFF_0001);
    drain();
    write_reg(CFG_ROW_WIDTH, 7'd12);
    send_word(OP_STEP, '0);
    drain();
    write_reg(CFG_ROW_WIDTH, 7'd64);
    send_word(OP_STEP, '0);
    drain();
  endtask

  task automatic test_long_step_run();
    quiet = 1'b1;
    write_reg(CFG_ROW_WIDTH, 7'd7);
    write_reg(CFG_RULE_CODE, 7'b0011010);
    send_word(OP_LOAD, 64'h5B);
    repeat (LONG_RUN_STEPS) send_word(OP_STEP, {$urandom, $urandom});
    drain();
    quiet = 1'b0;
  endtask

  task automatic test_random_runs();
    int unsigned sent;
    int unsigned run_len;
    logic [CFG_DATA_W-1:0] rule_val;
    logic [CFG_DATA_W-1:0] width_val;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      quiet = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 3))
        0: rule_val = 7'd0;
        1: rule_val = 7'h7F;
        default: rule_val = CFG_DATA_W'($urandom_range(0, 127));
      endcase
      case ($urandom_range(0, 5))
        0: width_val = CFG_DATA_W'($urandom_range(0, 4));
        1: width_val = 7'd5;
        2: width_val = 7'd64;
        3: width_val = CFG_DATA_W'($urandom_range(65, 127));
        default: width_val = CFG_DATA_W'($urandom_range(5, 64));
      endcase
      write_reg(CFG_RULE_CODE, rule_val);
      write_reg(CFG_ROW_WIDTH, width_val);
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 3) != 0) begin
          send_word(OP_LOAD, random_row());
          sent++;
        end
        run_len = $urandom_range(1, 12);
        repeat (run_len) begin
          if ($urandom_range(0, 7) == 0) send_word(OP_LOAD, random_row());
          else send_word(OP_STEP, {$urandom, $urandom});
        end
        sent += run_len;
      end
      drain();
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_op <= OP_LOAD;
    in_seed_row <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_RULE_CODE;
    cfg_data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_rule_bits();
    test_width_limits();
    test_width_change();
    test_long_step_run();
    test_random_runs();

    $display("Sent %0d load words and %0d step words across %0d register writes.",
             n_loads, n_steps, n_cfg);
    $display("Compared %0d result words, %0d failures found.", n_results, err_count);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
